FILE: hdl/hsd_pkg.sv
`default_nettype none

package hsd_pkg;

	localparam int unsigned COIL_W   = 4;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned LIMIT_W  = 16;

	localparam logic [LIMIT_W-1:0] STEP_LIMIT_RESET = 16'd1200;

	// item function codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// move direction codes
	localparam logic MOVE_OPEN  = 1'b0;
	localparam logic MOVE_CLOSE = 1'b1;

	// limit switch codes
	localparam logic [1:0] LIM_NONE  = 2'd0;
	localparam logic [1:0] LIM_OPEN  = 2'd1;
	localparam logic [1:0] LIM_CLOSE = 2'd2;
	localparam logic [1:0] LIM_BOTH  = 2'd3;

	typedef struct packed {
		logic       func;
		logic       move_direction;
		logic [1:0] limit_switches;
		logic       motor_moving;
	} item_t;

	typedef struct packed {
		logic [COIL_W-1:0] coil_pattern;
		logic              bridge_enable;
		logic              is_running;
		logic              timed_out;
		logic              finished;
		logic              finished_direction;
	} result_t;

	// eight-entry half-step coil table
	function automatic logic [COIL_W-1:0] half_step(input logic [IDX_W-1:0] idx);
		logic [COIL_W-1:0] pat;
		case (idx)
			3'd0:    pat = 4'd2;
			3'd1:    pat = 4'd6;
			3'd2:    pat = 4'd4;
			3'd3:    pat = 4'd5;
			3'd4:    pat = 4'd1;
			3'd5:    pat = 4'd9;
			3'd6:    pat = 4'd8;
			3'd7:    pat = 4'd10;
			default: pat = 4'd0;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/stepper_half_step_driver_top.sv
// Half-step sequencer for a two-phase stepper. A start item (func 0) arms a move in
// move_direction, clears the tick count and turns the bridge enables on; each tick item
// (func 1) during a move drives the next entry of the eight-entry half-step table and steps
// the index forward for open, back for close. A move stops when the count has reached
// step_limit or a closing motor is blocked (timed_out), or when the limit switch for the
// direction or both switches are hit; finished then pulses and coils and enables drop.
// Every input transfer gives exactly one result transfer. Each item passes through the input
// register and then the result register, and a stall at the result channel holds both;
// one item is taken per cycle as long as results are taken. step_limit resets to 1200 and
// is written through the cfg channel, which is always ready; write it only while no item is
// in flight.
`default_nettype none

module stepper_half_step_driver_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// input item channel
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        func,
	input  wire logic                        move_direction,
	input  wire logic [1:0]                  limit_switches,
	input  wire logic                        motor_moving,
	// configuration write channel
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [hsd_pkg::LIMIT_W-1:0] step_limit,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [hsd_pkg::COIL_W-1:0]       coil_pattern,
	output logic                             bridge_enable,
	output logic                             is_running,
	output logic                             timed_out,
	output logic                             finished,
	output logic                             finished_direction
);

	logic [hsd_pkg::LIMIT_W-1:0] limit_q;
	hsd_pkg::item_t              item_s1;
	logic                        valid_s1;
	hsd_pkg::result_t            result;
	hsd_pkg::result_t            result_q;
	logic                        can_load;
	logic                        fire;

	// config register transfer, taken in any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= hsd_pkg::STEP_LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= step_limit;
		end
	end

	// the input register moves on whenever the result register can take a new result
	assign fire     = valid_s1 && can_load;
	assign in_ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.func           <= func;
			item_s1.move_direction <= move_direction;
			item_s1.limit_switches <= limit_switches;
			item_s1.motor_moving   <= motor_moving;
		end
	end

	// sequencer state and next-result logic, state commits on fire
	hsd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.step_limit (limit_q),
		.result     (result)
	);

	// result register, holds a finished result while the consumer stalls
	hsd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.result    (result),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.can_load  (can_load),
		.result_q  (result_q)
	);

	assign coil_pattern       = result_q.coil_pattern;
	assign bridge_enable      = result_q.bridge_enable;
	assign is_running         = result_q.is_running;
	assign timed_out          = result_q.timed_out;
	assign finished           = result_q.finished;
	assign finished_direction = result_q.finished_direction;

endmodule

`default_nettype wire

FILE: hdl/hsd_core.sv
`default_nettype none

module hsd_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire hsd_pkg::item_t                item,
	input  wire logic [hsd_pkg::LIMIT_W-1:0]   step_limit,
	output hsd_pkg::result_t                   result
);

	logic [hsd_pkg::IDX_W-1:0]   index_q;
	logic [hsd_pkg::COUNT_W-1:0] count_q;
	logic                        dir_q;
	logic                        run_q;
	logic [hsd_pkg::COIL_W-1:0]  coil_q;
	logic                        en_q;

	logic [hsd_pkg::IDX_W-1:0]   index_d;
	logic [hsd_pkg::COUNT_W-1:0] count_d;
	logic                        dir_d;
	logic                        run_d;
	logic [hsd_pkg::COIL_W-1:0]  coil_d;
	logic                        en_d;
	logic                        in_limit;
	logic                        lim_hit;
	logic                        tmo;
	logic                        fin;

	always_comb begin
		index_d  = index_q;
		count_d  = count_q;
		dir_d    = dir_q;
		run_d    = run_q;
		coil_d   = coil_q;
		en_d     = en_q;
		tmo      = 1'b0;
		fin      = 1'b0;
		in_limit = count_q < step_limit;
		lim_hit  = ((dir_q == hsd_pkg::MOVE_OPEN) && (item.limit_switches == hsd_pkg::LIM_OPEN)) ||
			((dir_q == hsd_pkg::MOVE_CLOSE) && (item.limit_switches == hsd_pkg::LIM_CLOSE)) ||
			(item.limit_switches == hsd_pkg::LIM_BOTH);
		if (item.func == hsd_pkg::FUNC_START) begin
			count_d = '0;
			dir_d   = item.move_direction;
			en_d    = 1'b1;
			run_d   = 1'b1;
		end else if (run_q) begin
			coil_d  = hsd_pkg::half_step(index_q);
			index_d = (dir_q == hsd_pkg::MOVE_OPEN) ? index_q + 3'd1 : index_q - 3'd1;
			count_d = count_q + 16'd1;
			// step limit reached or closing motor blocked
			if (!in_limit || ((dir_q == hsd_pkg::MOVE_CLOSE) && !item.motor_moving)) begin
				tmo = 1'b1;
			end
			if (tmo || lim_hit) begin
				coil_d = '0;
				en_d   = 1'b0;
				run_d  = 1'b0;
				fin    = 1'b1;
			end
		end
		result.coil_pattern       = coil_d;
		result.bridge_enable      = en_d;
		result.is_running         = run_d;
		result.timed_out          = tmo;
		result.finished           = fin;
		result.finished_direction = fin & dir_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			count_q <= '0;
			dir_q   <= hsd_pkg::MOVE_OPEN;
			run_q   <= 1'b0;
			coil_q  <= '0;
			en_q    <= 1'b0;
		end else if (fire) begin
			index_q <= index_d;
			count_q <= count_d;
			dir_q   <= dir_d;
			run_q   <= run_d;
			coil_q  <= coil_d;
			en_q    <= en_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/hsd_out_reg.sv
`default_nettype none

module hsd_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire hsd_pkg::result_t result,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic                  can_load,
	output hsd_pkg::result_t      result_q
);

	logic valid_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			result_q <= result;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/hsd_checker.sv
`default_nettype none

module hsd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [3:0] coil_pattern,
	input wire logic       bridge_enable,
	input wire logic       is_running,
	input wire logic       timed_out,
	input wire logic       finished,
	input wire logic       finished_direction
);

	// a stop drops coils, enables and the run flag
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> !is_running && !bridge_enable && (coil_pattern == 4'd0))
		else $error("stop did not clear the drive");

	a_timeout_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> finished)
		else $error("timeout without stop");

	a_fin_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finished |-> !finished_direction)
		else $error("finished_direction set without stop");

	// enables follow the run flag
	a_enable_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bridge_enable == is_running))
		else $error("bridge enable out of step with run flag");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(coil_pattern) && $stable(finished))
		else $error("stalled result changed");

endmodule

bind stepper_half_step_driver_top hsd_checker u_hsd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.coil_pattern       (coil_pattern),
	.bridge_enable      (bridge_enable),
	.is_running         (is_running),
	.timed_out          (timed_out),
	.finished           (finished),
	.finished_direction (finished_direction)
);

`default_nettype wire
